// ===== sv/oth_pkg.sv =====
`default_nettype none
package oth_pkg;

	localparam int SampleW   = 16;
	localparam int BinW      = 8;
	localparam int BinCount  = 256;
	localparam int CountW    = 25;
	localparam int SumW      = 32;
	localparam int ProdW     = 57;
	localparam int NumW      = 114;
	localparam int DenW      = 50;
	localparam int MulAW     = 114;
	localparam int MulBW     = 57;
	localparam int MulPW     = MulAW + MulBW;
	localparam int ApbAddrW  = 3;
	localparam int ApbDataW  = 32;

	localparam logic [CountW-1:0] MaxVoxels = CountW'(25'd16777216);
	localparam logic [BinW-1:0]   LastBin   = BinW'(BinCount - 1);

	localparam logic RegRangeMin = 1'b0;
	localparam logic RegRangeMax = 1'b1;

	typedef struct packed {
		logic [BinW-1:0] bin;
		logic            last;
	} oth_item_t;

endpackage
`default_nettype wire

// ===== sv/oth_front.sv =====
`default_nettype none
module oth_front (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire  [oth_pkg::SampleW-1:0] sample,
	input  wire                         last_sample,
	input  wire                         in_valid,
	output logic                        in_ready,
	input  wire  [oth_pkg::SampleW-1:0] range_min,
	input  wire  [oth_pkg::SampleW-1:0] range_max,
	output logic                        push,
	output oth_pkg::oth_item_t          push_item,
	input  wire                         q_full
);
	import oth_pkg::*;

	typedef enum logic [3:0] {
		F_IDLE = 4'b0001,
		F_PREP = 4'b0010,
		F_DIV  = 4'b0100,
		F_PUSH = 4'b1000
	} front_state_t;

	front_state_t        state_q;
	logic [SampleW-1:0]  sample_q;
	logic                last_q;
	logic [SampleW-1:0]  rem_q;
	logic [BinW-1:0]     lo_q;
	logic [BinW-1:0]     quo_q;
	logic [2:0]          cnt_q;
	logic [SampleW-1:0]  diff;
	logic [SampleW-1:0]  span;
	logic [SampleW+7:0]  scaled;
	logic [SampleW:0]    trial;
	logic                fits;

	assign diff   = sample_q - range_min;
	assign span   = range_max - range_min;
	assign scaled = {diff, 8'd0} - {8'd0, diff};
	assign trial  = {rem_q, lo_q[BinW-1]};
	assign fits   = trial >= {1'b0, span};

	assign in_ready  = state_q == F_IDLE;
	assign push      = (state_q == F_PUSH) && !q_full;
	assign push_item = '{bin: quo_q, last: last_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			unique case (state_q)
				F_IDLE: if (in_valid) state_q <= F_PREP;
				F_PREP: begin
					if (range_max <= range_min || sample_q <= range_min
							|| sample_q >= range_max) begin
						state_q <= F_PUSH;
					end else begin
						state_q <= F_DIV;
					end
				end
				F_DIV: if (cnt_q == 3'd7) state_q <= F_PUSH;
				F_PUSH: if (!q_full) state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && in_valid) begin
			sample_q <= sample;
			last_q   <= last_sample;
		end
		if (state_q == F_PREP) begin
			cnt_q <= 3'd0;
			rem_q <= scaled[SampleW+7:8];
			lo_q  <= scaled[7:0];
			if (range_max <= range_min || sample_q <= range_min) begin
				quo_q <= '0;
			end else begin
				quo_q <= LastBin;
			end
		end
		if (state_q == F_DIV) begin
			cnt_q <= cnt_q + 3'd1;
			lo_q  <= {lo_q[BinW-2:0], 1'b0};
			quo_q <= {quo_q[BinW-2:0], fits};
			rem_q <= fits ? SampleW'(trial - {1'b0, span}) : trial[SampleW-1:0];
		end
	end

endmodule
`default_nettype wire

// ===== sv/oth_queue.sv =====
`default_nettype none
module oth_queue (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push,
	input  oth_pkg::oth_item_t push_item,
	output logic               full,
	input  wire                pop,
	output oth_pkg::oth_item_t head,
	output logic               empty
);
	import oth_pkg::*;

	oth_item_t  slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;

	assign full  = fill_q == 2'd2;
	assign empty = fill_q == 2'd0;
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push && !full) wr_ptr_q <= ~wr_ptr_q;
			if (pop && !empty) rd_ptr_q <= ~rd_ptr_q;
			case ({push && !full, pop && !empty})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) slot_q[wr_ptr_q] <= push_item;
	end

endmodule
`default_nettype wire

// ===== sv/oth_mul.sv =====
`default_nettype none
module oth_mul (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       start,
	input  wire  [oth_pkg::MulAW-1:0] a,
	input  wire  [oth_pkg::MulBW-1:0] b,
	output logic [oth_pkg::MulPW-1:0] p,
	output logic                      done
);
	import oth_pkg::*;

	logic             busy_q;
	logic [MulPW-1:0] a_q;
	logic [MulBW-1:0] b_q;
	logic [MulPW-1:0] p_q;

	assign done = busy_q && (b_q == '0);
	assign p    = p_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= MulPW'(a);
			b_q <= b;
			p_q <= '0;
		end else if (busy_q && b_q != '0) begin
			if (b_q[0]) p_q <= p_q + a_q;
			a_q <= {a_q[MulPW-2:0], 1'b0};
			b_q <= {1'b0, b_q[MulBW-1:1]};
		end
	end

endmodule
`default_nettype wire

// ===== sv/oth_back.sv =====
`default_nettype none
module oth_back (
	input  wire                         clk,
	input  wire                         arst_n,
	input  oth_pkg::oth_item_t          head,
	input  wire                         q_empty,
	output logic                        pop,
	input  wire  [oth_pkg::SampleW-1:0] range_min,
	input  wire  [oth_pkg::SampleW-1:0] range_max,
	output logic                        out_valid,
	input  wire                         out_ready,
	output logic [oth_pkg::BinW-1:0]    out_bin,
	output logic [oth_pkg::SampleW-1:0] out_value
);
	import oth_pkg::*;

	typedef enum logic [12:0] {
		B_IDLE = 13'b0000000000001,
		B_UPD  = 13'b0000000000010,
		S_RD   = 13'b0000000000100,
		S_ACC  = 13'b0000000001000,
		S_CHK  = 13'b0000000010000,
		S_MX   = 13'b0000000100000,
		S_MY   = 13'b0000001000000,
		S_MD   = 13'b0000010000000,
		S_MDEN = 13'b0000100000000,
		S_ML   = 13'b0001000000000,
		S_MR   = 13'b0010000000000,
		S_FIN  = 13'b0100000000000,
		S_OUT  = 13'b1000000000000
	} back_state_t;

	back_state_t          state_q;
	logic [CountW-1:0]    hist_mem [BinCount];
	logic [BinCount-1:0]  vld_q;
	logic [CountW-1:0]    rd_data_q;
	logic                 rd_vld_q;
	logic                 rd_en;
	logic [BinW-1:0]      rd_addr;
	logic                 wr_en;
	logic [CountW-1:0]    wr_data;

	logic [BinW-1:0]      bin_q;
	logic                 last_q;
	logic [CountW-1:0]    total_q;
	logic [SumW-1:0]      sum_q;
	logic [CountW-1:0]    n_a_q;
	logic [SumW-1:0]      s_a_q;
	logic [ProdW-1:0]     x_q;
	logic [NumW-1:0]      num_q;
	logic [DenW-1:0]      den_q;
	logic [MulPW-1:0]     lhs_q;
	logic [NumW-1:0]      best_num_q;
	logic [DenW-1:0]      best_den_q;
	logic [BinW-1:0]      best_bin_q;
	logic [SampleW-1:0]   value_q;

	logic                 mul_start_q;
	logic [MulAW-1:0]     mul_a_q;
	logic [MulBW-1:0]     mul_b_q;
	logic [MulPW-1:0]     mul_p;
	logic                 mul_done;

	logic [CountW-1:0]    cnt;
	logic [CountW+BinW-1:0] wsum;
	logic [CountW-1:0]    n_b;
	logic [ProdW-1:0]     y;
	logic [ProdW-1:0]     d;
	logic [SampleW-1:0]   span;
	logic [SampleW+BinW-1:0] tscale;
	logic                 counting;

	oth_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start_q),
		.a      (mul_a_q),
		.b      (mul_b_q),
		.p      (mul_p),
		.done   (mul_done)
	);

	assign counting = total_q < MaxVoxels;
	assign cnt      = rd_vld_q ? rd_data_q : '0;
	assign wsum     = (bin_q - BinW'(1)) * cnt;
	assign n_b      = total_q - n_a_q;
	assign y        = mul_p[ProdW-1:0];
	assign d        = (x_q >= y) ? (x_q - y) : (y - x_q);
	assign span     = (range_max > range_min) ? (range_max - range_min) : '0;
	assign tscale   = span * best_bin_q;

	assign pop     = (state_q == B_IDLE) && !q_empty;
	assign rd_en   = pop || (state_q == S_RD);
	assign rd_addr = pop ? head.bin : bin_q - BinW'(1);
	assign wr_en   = state_q == B_UPD;
	assign wr_data = cnt + CountW'(1);

	assign out_valid = state_q == S_OUT;
	assign out_bin   = best_bin_q;
	assign out_value = value_q;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= hist_mem[rd_addr];
			rd_vld_q  <= vld_q[rd_addr];
		end
		if (wr_en) hist_mem[bin_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			vld_q       <= '0;
			total_q     <= '0;
			sum_q       <= '0;
			mul_start_q <= 1'b0;
		end else begin
			mul_start_q <= 1'b0;
			unique case (state_q)
				B_IDLE: begin
					if (!q_empty) begin
						if (counting) begin
							state_q <= B_UPD;
						end else if (head.last) begin
							state_q <= S_RD;
						end
					end
				end
				B_UPD: begin
					vld_q[bin_q] <= 1'b1;
					total_q      <= total_q + CountW'(1);
					sum_q        <= sum_q + SumW'(bin_q);
					state_q      <= last_q ? S_RD : B_IDLE;
				end
				S_RD:  state_q <= S_ACC;
				S_ACC: state_q <= S_CHK;
				S_CHK: begin
					if (n_a_q == '0 || n_b == '0) begin
						state_q <= (bin_q == LastBin) ? S_FIN : S_RD;
					end else begin
						mul_start_q <= 1'b1;
						state_q     <= S_MX;
					end
				end
				S_MX: if (mul_done) begin
					mul_start_q <= 1'b1;
					state_q     <= S_MY;
				end
				S_MY: if (mul_done) begin
					mul_start_q <= 1'b1;
					state_q     <= S_MD;
				end
				S_MD: if (mul_done) begin
					mul_start_q <= 1'b1;
					state_q     <= S_MDEN;
				end
				S_MDEN: if (mul_done) begin
					mul_start_q <= 1'b1;
					state_q     <= S_ML;
				end
				S_ML: if (mul_done) begin
					mul_start_q <= 1'b1;
					state_q     <= S_MR;
				end
				S_MR: if (mul_done) begin
					state_q <= (bin_q == LastBin) ? S_FIN : S_RD;
				end
				S_FIN: state_q <= S_OUT;
				S_OUT: if (out_ready) begin
					vld_q   <= '0;
					total_q <= '0;
					sum_q   <= '0;
					state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				bin_q      <= head.bin;
				last_q     <= head.last;
				n_a_q      <= '0;
				s_a_q      <= '0;
				best_num_q <= '0;
				best_den_q <= DenW'(1);
				best_bin_q <= '0;
				if (!counting) bin_q <= BinW'(1);
			end
			B_UPD: begin
				bin_q      <= BinW'(1);
				n_a_q      <= '0;
				s_a_q      <= '0;
				best_num_q <= '0;
				best_den_q <= DenW'(1);
				best_bin_q <= '0;
			end
			S_ACC: begin
				n_a_q <= n_a_q + cnt;
				s_a_q <= s_a_q + wsum[SumW-1:0];
			end
			S_CHK: begin
				mul_a_q <= MulAW'(s_a_q);
				mul_b_q <= MulBW'(total_q);
				if (n_a_q == '0 || n_b == '0) bin_q <= bin_q + BinW'(1);
			end
			S_MX: if (mul_done) begin
				x_q     <= mul_p[ProdW-1:0];
				mul_a_q <= MulAW'(n_a_q);
				mul_b_q <= MulBW'(sum_q);
			end
			S_MY: if (mul_done) begin
				mul_a_q <= MulAW'(d);
				mul_b_q <= d;
			end
			S_MD: if (mul_done) begin
				num_q   <= mul_p[NumW-1:0];
				mul_a_q <= MulAW'(n_a_q);
				mul_b_q <= MulBW'(n_b);
			end
			S_MDEN: if (mul_done) begin
				den_q   <= mul_p[DenW-1:0];
				mul_a_q <= num_q;
				mul_b_q <= MulBW'(best_den_q);
			end
			S_ML: if (mul_done) begin
				lhs_q   <= mul_p;
				mul_a_q <= best_num_q;
				mul_b_q <= MulBW'(den_q);
			end
			S_MR: if (mul_done) begin
				if (lhs_q > mul_p) begin
					best_num_q <= num_q;
					best_den_q <= den_q;
					best_bin_q <= bin_q;
				end
				bin_q <= bin_q + BinW'(1);
			end
			S_FIN: value_q <= range_min + tscale[SampleW+BinW-1:BinW];
			default: ;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= MaxVoxels)
		else $error("voxel total beyond limit");

	assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == S_MX || state_q == S_MY || state_q == S_MD
			|| state_q == S_MDEN || state_q == S_ML || state_q == S_MR))
		else $error("multiplier finished outside a product step");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD) |-> (bin_q != '0 && best_den_q != '0))
		else $error("split search on bin zero or zero denominator");

endmodule
`default_nettype wire

// ===== sv/otsu_threshold_histogram.sv =====
`default_nettype none
// Otsu threshold over a 256-bin histogram. Samples are binned against range_min/range_max
// by a shift-subtract divider, and the input side takes a new sample only after the previous
// one has been pushed; a two-item queue feeds the histogram, which counts each item with
// one memory read and one write. The item with tlast set starts the split search over
// bins 1..255, where every bin with two non-empty classes runs six products through one
// shift-add multiplier, one multiplier bit a cycle. One result (bin, value) follows each
// tlast item; the histogram is cleared when that result is accepted. Configuration must
// only be written while the block is idle; the block itself does not enforce this.
module otsu_threshold_histogram (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          s_tvalid,
	output logic                         s_tready,
	input  wire  [15:0]                  s_tdata,  // sample
	input  wire                          s_tlast,
	output logic                         m_tvalid,
	input  wire                          m_tready,
	output logic [23:0]                  m_tdata,  // threshold_value, threshold_bin
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire  [oth_pkg::ApbAddrW-1:0] paddr,
	input  wire  [oth_pkg::ApbDataW-1:0] pwdata,
	output logic [oth_pkg::ApbDataW-1:0] prdata,
	output logic                         pready
);
	import oth_pkg::*;

	logic [SampleW-1:0] range_min_q;
	logic [SampleW-1:0] range_max_q;
	logic               q_push;
	oth_item_t          q_in;
	logic               q_full;
	logic               q_pop;
	oth_item_t          q_head;
	logic               q_empty;
	logic [BinW-1:0]    res_bin;
	logic [SampleW-1:0] res_value;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_min_q <= '0;
			range_max_q <= '1;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				RegRangeMin: range_min_q <= pwdata[SampleW-1:0];
				RegRangeMax: range_max_q <= pwdata[SampleW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			RegRangeMin: prdata = ApbDataW'(range_min_q);
			RegRangeMax: prdata = ApbDataW'(range_max_q);
			default:     prdata = '0;
		endcase
	end

	oth_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample      (s_tdata),
		.last_sample (s_tlast),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.range_min   (range_min_q),
		.range_max   (range_max_q),
		.push        (q_push),
		.push_item   (q_in),
		.q_full      (q_full)
	);

	oth_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty)
	);

	oth_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.q_empty   (q_empty),
		.pop       (q_pop),
		.range_min (range_min_q),
		.range_max (range_max_q),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_bin   (res_bin),
		.out_value (res_value)
	);

	assign m_tdata = {res_value, res_bin};

endmodule
`default_nettype wire
